// ===== sv/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // Verdict codes
    localparam logic [1:0] VERDICT_UNCONFIGURED = 2'd0;
    localparam logic [1:0] VERDICT_INVALID      = 2'd1;
    localparam logic [1:0] VERDICT_CONFIGURED   = 2'd2;

    // Reason codes
    localparam logic REASON_OK     = 1'b0;
    localparam logic REASON_BAD_CFG = 1'b1;

    // Label and octet limits fixed by the field widths
    localparam logic [6:0] LABEL_LEN_SAT = 7'd64;
    localparam logic [8:0] OCTET_SAT     = 9'd256;
    localparam logic [8:0] OCTET_MAX     = 9'd255;
    localparam logic [6:0] OCTET_DIGITS  = 7'd3;
    localparam int         QUAD_LABELS   = 4;

    // Queue between classifier and checker
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic       is_end;
        logic       is_dot;
        logic       is_hyphen;
        logic       is_digit;
        logic       is_legal;
        logic [3:0] digit;
    } t_byte_class;

endpackage

`default_nettype wire

// ===== sv/hsc_front.sv =====
`default_nettype none

module hsc_front (
    input  wire logic [7:0]          i_name_byte,
    output hsc_pkg::t_byte_class     o_class
);

    logic w_digit;
    logic w_alpha;

    assign w_digit = (i_name_byte >= hsc_pkg::CH_ZERO) && (i_name_byte <= hsc_pkg::CH_NINE);
    assign w_alpha = ((i_name_byte >= hsc_pkg::CH_LOWER_A) &&
                      (i_name_byte <= hsc_pkg::CH_LOWER_Z)) ||
                     ((i_name_byte >= hsc_pkg::CH_UPPER_A) &&
                      (i_name_byte <= hsc_pkg::CH_UPPER_Z));

    always_comb begin
        o_class.is_end    = (i_name_byte == hsc_pkg::CH_NUL);
        o_class.is_dot    = (i_name_byte == hsc_pkg::CH_DOT);
        o_class.is_hyphen = (i_name_byte == hsc_pkg::CH_HYPHEN);
        o_class.is_digit  = w_digit;
        o_class.is_legal  = w_alpha || w_digit || o_class.is_dot || o_class.is_hyphen;
        // '0'..'9' carry their value in the low nibble
        o_class.digit     = i_name_byte[3:0];
    end

endmodule

`default_nettype wire

// ===== sv/hsc_queue.sv =====
`default_nettype none

module hsc_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire hsc_pkg::t_byte_class i_item,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_pop,
    output hsc_pkg::t_byte_class      o_item
);

    hsc_pkg::t_byte_class r_slot [hsc_pkg::QUEUE_DEPTH];
    logic [hsc_pkg::QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [hsc_pkg::QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [hsc_pkg::QUEUE_CNT_W-1:0] r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_count == hsc_pkg::QUEUE_CNT_W'(hsc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hsc_pkg::QUEUE_CNT_W'(hsc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

`default_nettype wire

// ===== sv/hsc_back.sv =====
`default_nettype none

module hsc_back #(
    parameter int MAX_NAME_BYTES  = 253,
    parameter int MAX_LABEL_BYTES = 63,
    parameter int MAX_LABELS      = 127
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire hsc_pkg::t_byte_class i_q_item,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_verdict,
    output logic                      o_usable,
    output logic [7:0]                o_name_length,
    output logic [6:0]                o_label_total,
    output logic                      o_is_ipv4_literal,
    output logic                      o_reason_code
);

    localparam int CW = $clog2(MAX_NAME_BYTES + 2);
    localparam int LW = $clog2(MAX_LABELS + 1);

    logic [CW-1:0] r_byte_count,   n_byte_count;
    logic [6:0]    r_lbl_bytes,    n_lbl_bytes;
    logic [LW-1:0] r_labels,       n_labels;
    logic [LW-1:0] r_num_labels,   n_num_labels;
    logic          r_all_digits,   n_all_digits;
    logic          r_first_hyphen, n_first_hyphen;
    logic          r_first_zero,   n_first_zero;
    logic          r_prev_hyphen,  n_prev_hyphen;
    logic          r_last_numeric, n_last_numeric;
    logic [8:0]    r_octet,        n_octet;
    logic          r_octets_ok,    n_octets_ok;
    logic          r_name_bad,     n_name_bad;

    logic          r_out_valid;
    logic [1:0]    r_verdict,  n_verdict;
    logic [CW-1:0] r_length,   n_length;
    logic [LW-1:0] r_ltotal,   n_ltotal;
    logic          r_literal,  n_literal;

    // Label close, evaluated from current state
    logic          c_bad;
    logic [LW-1:0] c_labels;
    logic [LW-1:0] c_num_labels;
    logic          c_octet_ok;
    logic          w_labels_full;
    logic [11:0]   w_octet_next;
    logic          w_end_bad;
    logic          w_pop;
    logic          w_end;

    logic [CW+7:0] w_len_ext;
    logic [LW+6:0] w_lab_ext;

    assign w_end   = i_q_item.is_end;
    assign w_pop   = i_q_valid && (!w_end || !r_out_valid || !i_out_stall);
    assign o_q_pop = w_pop;

    always_comb begin
        w_labels_full = (r_labels >= LW'(MAX_LABELS));
        c_bad = (r_lbl_bytes == '0) || (r_lbl_bytes > 7'(MAX_LABEL_BYTES)) ||
                r_first_hyphen || r_prev_hyphen || w_labels_full;
        c_labels     = w_labels_full ? r_labels : r_labels + 1'b1;
        c_num_labels = (!w_labels_full && r_all_digits) ? r_num_labels + 1'b1 : r_num_labels;
        c_octet_ok   = r_all_digits && (r_lbl_bytes != '0) &&
                       (r_lbl_bytes <= hsc_pkg::OCTET_DIGITS) &&
                       !((r_lbl_bytes > 7'd1) && r_first_zero) &&
                       (r_octet <= hsc_pkg::OCTET_MAX);
        w_octet_next = 12'(r_octet) * 12'd10 + 12'(i_q_item.digit);
    end

    always_comb begin
        n_byte_count   = r_byte_count;
        n_lbl_bytes    = r_lbl_bytes;
        n_labels       = r_labels;
        n_num_labels   = r_num_labels;
        n_all_digits   = r_all_digits;
        n_first_hyphen = r_first_hyphen;
        n_first_zero   = r_first_zero;
        n_prev_hyphen  = r_prev_hyphen;
        n_last_numeric = r_last_numeric;
        n_octet        = r_octet;
        n_octets_ok    = r_octets_ok;
        n_name_bad     = r_name_bad;
        n_verdict      = r_verdict;
        n_length       = r_length;
        n_ltotal       = r_ltotal;
        n_literal      = r_literal;
        w_end_bad      = 1'b0;

        if (w_pop && !w_end) begin
            if (r_byte_count <= CW'(MAX_NAME_BYTES)) begin
                n_byte_count = r_byte_count + 1'b1;
            end
            if (!i_q_item.is_legal) begin
                n_name_bad = 1'b1;
            end
            if (i_q_item.is_dot) begin
                n_name_bad     = r_name_bad || c_bad || !i_q_item.is_legal;
                n_labels       = c_labels;
                n_num_labels   = c_num_labels;
                n_last_numeric = r_all_digits;
                n_octets_ok    = r_octets_ok && c_octet_ok;
                n_lbl_bytes    = '0;
                n_all_digits   = 1'b1;
                n_first_hyphen = 1'b0;
                n_first_zero   = 1'b0;
                n_prev_hyphen  = 1'b0;
                n_octet        = '0;
            end else begin
                if (r_lbl_bytes == '0) begin
                    n_first_hyphen = i_q_item.is_hyphen;
                    n_first_zero   = i_q_item.is_digit && (i_q_item.digit == 4'd0);
                end
                if (r_lbl_bytes < hsc_pkg::LABEL_LEN_SAT) begin
                    n_lbl_bytes = r_lbl_bytes + 1'b1;
                end
                if (i_q_item.is_digit) begin
                    n_octet = (w_octet_next > 12'(hsc_pkg::OCTET_SAT)) ?
                              hsc_pkg::OCTET_SAT : w_octet_next[8:0];
                end else begin
                    n_all_digits = 1'b0;
                end
                n_prev_hyphen = i_q_item.is_hyphen;
            end
        end else if (w_pop && w_end) begin
            n_length  = '0;
            n_ltotal  = '0;
            n_literal = 1'b0;
            if (r_byte_count == '0) begin
                n_verdict = hsc_pkg::VERDICT_UNCONFIGURED;
            end else begin
                w_end_bad = r_name_bad || c_bad || (r_byte_count > CW'(MAX_NAME_BYTES)) ||
                            (c_labels < LW'(2));
                if (!w_end_bad) begin
                    if (c_num_labels == c_labels) begin
                        if ((c_labels != LW'(hsc_pkg::QUAD_LABELS)) ||
                            !(r_octets_ok && c_octet_ok)) begin
                            w_end_bad = 1'b1;
                        end else begin
                            n_literal = 1'b1;
                        end
                    end else if (r_all_digits) begin
                        w_end_bad = 1'b1;
                    end
                end
                if (w_end_bad) begin
                    n_verdict = hsc_pkg::VERDICT_INVALID;
                    n_literal = 1'b0;
                end else begin
                    n_verdict = hsc_pkg::VERDICT_CONFIGURED;
                    n_length  = r_byte_count;
                    n_ltotal  = c_labels;
                end
            end
            // start over for the next name
            n_byte_count   = '0;
            n_labels       = '0;
            n_num_labels   = '0;
            n_last_numeric = 1'b0;
            n_octets_ok    = 1'b1;
            n_name_bad     = 1'b0;
            n_lbl_bytes    = '0;
            n_all_digits   = 1'b1;
            n_first_hyphen = 1'b0;
            n_first_zero   = 1'b0;
            n_prev_hyphen  = 1'b0;
            n_octet        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_lbl_bytes    <= '0;
            r_labels       <= '0;
            r_num_labels   <= '0;
            r_all_digits   <= 1'b1;
            r_first_hyphen <= 1'b0;
            r_first_zero   <= 1'b0;
            r_prev_hyphen  <= 1'b0;
            r_last_numeric <= 1'b0;
            r_octet        <= '0;
            r_octets_ok    <= 1'b1;
            r_name_bad     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_lbl_bytes    <= n_lbl_bytes;
            r_labels       <= n_labels;
            r_num_labels   <= n_num_labels;
            r_all_digits   <= n_all_digits;
            r_first_hyphen <= n_first_hyphen;
            r_first_zero   <= n_first_zero;
            r_prev_hyphen  <= n_prev_hyphen;
            r_last_numeric <= n_last_numeric;
            r_octet        <= n_octet;
            r_octets_ok    <= n_octets_ok;
            r_name_bad     <= n_name_bad;
            if (w_pop && w_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        r_length  <= n_length;
        r_ltotal  <= n_ltotal;
        r_literal <= n_literal;
    end

    // mask counts to the result field widths
    assign w_len_ext = {8'd0, r_length};
    assign w_lab_ext = {7'd0, r_ltotal};

    assign o_out_valid       = r_out_valid;
    assign o_verdict         = r_verdict;
    assign o_usable          = (r_verdict == hsc_pkg::VERDICT_CONFIGURED);
    assign o_name_length     = w_len_ext[7:0];
    assign o_label_total     = w_lab_ext[6:0];
    assign o_is_ipv4_literal = r_literal;
    assign o_reason_code     = (r_verdict == hsc_pkg::VERDICT_INVALID) ?
                               hsc_pkg::REASON_BAD_CFG : hsc_pkg::REASON_OK;

    a_literal_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_literal) |-> (r_ltotal == LW'(hsc_pkg::QUAD_LABELS)) &&
                                       (r_verdict == hsc_pkg::VERDICT_CONFIGURED))
        else $error("address literal without four labels");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && w_end) |=> (r_byte_count == '0) && (r_labels == '0) && r_out_valid)
        else $error("state not cleared after terminator");

    a_label_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lbl_bytes <= hsc_pkg::LABEL_LEN_SAT)
        else $error("label length past saturation");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(w_pop && w_end))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sv/hostname_syntax_checker_core.sv =====
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_name_byte
// out      | output    | o_out_valid / i_out_stall  | o_verdict .. o_reason_code
//
// One name byte is taken per cycle unless o_in_stall is high.
// o_out_valid is a register set when the checker pops the zero byte off the queue.
// A four-entry queue sits between the classifier and the checker; o_in_stall
// rises only when that queue is full, i.e. after the output has been held.
// Reset is synchronous and active low; no clearing pass.
module hostname_syntax_checker_core #(
    parameter int MAX_NAME_BYTES  = 253,
    parameter int MAX_LABEL_BYTES = 63,
    parameter int MAX_LABELS      = 127
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_name_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_verdict,
    output logic            o_usable,
    output logic [7:0]      o_name_length,
    output logic [6:0]      o_label_total,
    output logic            o_is_ipv4_literal,
    output logic            o_reason_code
);

    hsc_pkg::t_byte_class w_class;
    hsc_pkg::t_byte_class w_q_item;
    logic                 w_q_full;
    logic                 w_q_valid;
    logic                 w_q_pop;

    assign o_in_stall = w_q_full;

    hsc_front u_front (
        .i_name_byte (i_name_byte),
        .o_class     (w_class)
    );

    hsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (w_class),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    hsc_back #(
        .MAX_NAME_BYTES  (MAX_NAME_BYTES),
        .MAX_LABEL_BYTES (MAX_LABEL_BYTES),
        .MAX_LABELS      (MAX_LABELS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_verdict         (o_verdict),
        .o_usable          (o_usable),
        .o_name_length     (o_name_length),
        .o_label_total     (o_label_total),
        .o_is_ipv4_literal (o_is_ipv4_literal),
        .o_reason_code     (o_reason_code)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

typedef struct packed {
    logic [1:0] verdict;
    logic       usable;
    logic [7:0] name_length;
    logic [6:0] label_total;
    logic       ipv4_literal;
    logic       reason;
} t_hostname_verdict;

class hostname_verdict_board #(
    parameter int MAX_NAME_BYTES  = 253,
    parameter int MAX_LABEL_BYTES = 63,
    parameter int MAX_LABELS      = 127
);
    t_hostname_verdict pending_verdicts[$];
    int unsigned       failures;

    int unsigned byte_cnt;
    int unsigned lbl_bytes;
    int unsigned labels_closed;
    int unsigned digit_labels;
    int unsigned octet_val;
    bit          label_digits;
    bit          label_hyphen_first;
    bit          label_zero_first;
    bit          prev_hyphen;
    bit          last_numeric;
    bit          octets_ok;
    bit          name_bad;

    function new();
        failures = 0;
        restart_name();
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= hsc_pkg::CH_ZERO && b <= hsc_pkg::CH_NINE;
    endfunction

    function bit is_name_char(logic [7:0] b);
        return (b >= hsc_pkg::CH_LOWER_A && b <= hsc_pkg::CH_LOWER_Z) ||
               (b >= hsc_pkg::CH_UPPER_A && b <= hsc_pkg::CH_UPPER_Z) ||
               is_digit(b) || b == hsc_pkg::CH_HYPHEN || b == hsc_pkg::CH_DOT;
    endfunction

    function void clear_label();
        lbl_bytes          = 0;
        label_digits       = 1;
        label_hyphen_first = 0;
        label_zero_first   = 0;
        prev_hyphen        = 0;
        octet_val          = 0;
    endfunction

    function void restart_name();
        byte_cnt       = 0;
        labels_closed  = 0;
        digit_labels   = 0;
        last_numeric   = 0;
        octets_ok      = 1;
        name_bad       = 0;
        clear_label();
    endfunction

    function void close_label();
        if (lbl_bytes == 0 || lbl_bytes > MAX_LABEL_BYTES) name_bad = 1;
        if (label_hyphen_first || prev_hyphen) name_bad = 1;
        // label counters stop at the limit; any further label only marks the name bad
        if (labels_closed >= MAX_LABELS) begin
            name_bad = 1;
        end else begin
            if (label_digits) digit_labels++;
            labels_closed++;
        end
        last_numeric = label_digits;
        if (!(label_digits && lbl_bytes >= 1 && lbl_bytes <= 3 &&
              !(lbl_bytes > 1 && label_zero_first) && octet_val <= 255))
            octets_ok = 0;
        clear_label();
    endfunction

    function void take_byte(logic [7:0] b);
        t_hostname_verdict v;
        bit                reject;
        if (b != hsc_pkg::CH_NUL) begin
            if (byte_cnt <= MAX_NAME_BYTES) byte_cnt++;
            if (!is_name_char(b)) name_bad = 1;
            if (b == hsc_pkg::CH_DOT) begin
                close_label();
            end else begin
                if (lbl_bytes == 0) begin
                    label_hyphen_first = (b == hsc_pkg::CH_HYPHEN);
                    label_zero_first   = (b == hsc_pkg::CH_ZERO);
                end
                if (lbl_bytes < 64) lbl_bytes++;
                if (is_digit(b)) begin
                    octet_val = octet_val * 10 + int'(b - hsc_pkg::CH_ZERO);
                    if (octet_val > 256) octet_val = 256;
                end else begin
                    label_digits = 0;
                end
                prev_hyphen = (b == hsc_pkg::CH_HYPHEN);
            end
            return;
        end
        v = '0;
        if (byte_cnt == 0) begin
            v.verdict = hsc_pkg::VERDICT_UNCONFIGURED;
        end else begin
            close_label();
            reject = name_bad || byte_cnt > MAX_NAME_BYTES || labels_closed < 2;
            if (!reject) begin
                if (digit_labels == labels_closed) begin
                    if (labels_closed != 4 || !octets_ok) reject = 1;
                    else v.ipv4_literal = 1;
                end else if (last_numeric) begin
                    reject = 1;
                end
            end
            if (reject) begin
                v.verdict      = hsc_pkg::VERDICT_INVALID;
                v.ipv4_literal = 0;
                v.reason       = hsc_pkg::REASON_BAD_CFG;
            end else begin
                v.verdict     = hsc_pkg::VERDICT_CONFIGURED;
                v.usable      = 1;
                v.name_length = byte_cnt[7:0];
                v.label_total = labels_closed[6:0];
                v.reason      = hsc_pkg::REASON_OK;
            end
        end
        pending_verdicts.push_back(v);
        restart_name();
    endfunction

    function void compare_field(string field, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", field, exp_val, got_val);
            failures++;
        end
    endfunction

    function void check_verdict(t_hostname_verdict got);
        t_hostname_verdict exp_v;
        if (pending_verdicts.size() == 0) begin
            $error("verdict transfer with none pending: %p", got);
            failures++;
            return;
        end
        exp_v = pending_verdicts.pop_front();
        compare_field("verdict", 8'(exp_v.verdict), 8'(got.verdict));
        compare_field("usable", 8'(exp_v.usable), 8'(got.usable));
        compare_field("name_length", exp_v.name_length, got.name_length);
        compare_field("label_total", 8'(exp_v.label_total), 8'(got.label_total));
        compare_field("is_ipv4_literal", 8'(exp_v.ipv4_literal), 8'(got.ipv4_literal));
        compare_field("reason_code", 8'(exp_v.reason), 8'(got.reason));
    endfunction
endclass

module tb;
    localparam int MAX_NAME_BYTES  = 253;
    localparam int MAX_LABEL_BYTES = 63;
    localparam int MAX_LABELS      = 127;
    localparam int RANDOM_BYTES    = 1100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_name_byte = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_verdict;
    logic       o_usable;
    logic [7:0] o_name_length;
    logic [6:0] o_label_total;
    logic       o_is_ipv4_literal;
    logic       o_reason_code;

    hostname_verdict_board #(MAX_NAME_BYTES, MAX_LABEL_BYTES, MAX_LABELS) board = new;

    logic [7:0] name_buf[$];
    bit         hold_now = 0;
    int         random_bytes = 0;

    hostname_syntax_checker_core #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES),
        .MAX_LABEL_BYTES(MAX_LABEL_BYTES),
        .MAX_LABELS     (MAX_LABELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_name_byte      (i_name_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_verdict        (o_verdict),
        .o_usable         (o_usable),
        .o_name_length    (o_name_length),
        .o_label_total    (o_label_total),
        .o_is_ipv4_literal(o_is_ipv4_literal),
        .o_reason_code    (o_reason_code)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return hsc_pkg::CH_ZERO + 8'(r);
        if (r < 36) return hsc_pkg::CH_UPPER_A + 8'(r - 10);
        return hsc_pkg::CH_LOWER_A + 8'(r - 36);
    endfunction

    function void push_str(string s);
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endfunction

    function void push_label(int len, bit digits_only);
        for (int i = 0; i < len; i++) begin
            if (digits_only)
                name_buf.push_back(hsc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            else if (i != 0 && i != len - 1 && $urandom_range(0, 5) == 0)
                name_buf.push_back(hsc_pkg::CH_HYPHEN);
            else
                name_buf.push_back(rand_alnum());
        end
    endfunction

    // labels joined by dots; each label is 'len' copies of 'ch'
    function void push_fixed_labels(int count, int len, logic [7:0] ch);
        for (int i = 0; i < count; i++) begin
            if (i > 0) name_buf.push_back(hsc_pkg::CH_DOT);
            for (int j = 0; j < len; j++) name_buf.push_back(ch);
        end
    endfunction

    function void push_hostname();
        int n;
        int len;
        n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 5);
        for (int i = 0; i < n; i++) begin
            if (i > 0) name_buf.push_back(hsc_pkg::CH_DOT);
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 64) : $urandom_range(1, 10);
            push_label(len, $urandom_range(0, 4) == 0);
        end
    endfunction

    function void push_quad();
        int n;
        int k;
        n = ($urandom_range(0, 4) != 0) ? 4 : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            if (i > 0) name_buf.push_back(hsc_pkg::CH_DOT);
            k = $urandom_range(0, 19);
            if (k < 6)
                push_str($sformatf("%0d", $urandom_range(0, 9)));
            else if (k < 14)
                push_str($sformatf("%0d", $urandom_range(0, 255)));
            else if (k < 16)
                push_str($sformatf("0%0d", $urandom_range(0, 99)));
            else if (k < 18)
                push_str($sformatf("%0d", $urandom_range(256, 999)));
            else if (k < 19)
                push_str($sformatf("%0d", $urandom_range(1000, 99999)));
        end
    endfunction

    function void build_random_name();
        int r;
        int target;
        name_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 45) begin
            push_hostname();
        end else if (r < 65) begin
            push_quad();
        end else if (r < 80) begin
            push_hostname();
            case ($urandom_range(0, 3))
                0: name_buf[$urandom_range(0, name_buf.size() - 1)] = 8'($urandom_range(1, 255));
                1: name_buf[$urandom_range(0, name_buf.size() - 1)] = hsc_pkg::CH_HYPHEN;
                2: name_buf[$urandom_range(0, name_buf.size() - 1)] = hsc_pkg::CH_DOT;
                default: name_buf.push_front(hsc_pkg::CH_HYPHEN);
            endcase
        end else if (r < 92) begin
            repeat ($urandom_range(1, 10)) name_buf.push_back(8'($urandom_range(1, 255)));
        end else if (r < 97) begin
            // empty name: terminator only
        end else begin
            target = $urandom_range(240, 270);
            while (name_buf.size() < target) begin
                if (name_buf.size() > 0) name_buf.push_back(hsc_pkg::CH_DOT);
                push_label($urandom_range(1, 63), 0);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_name_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.take_byte(b);
    endtask

    task automatic send_name();
        bit burst;
        burst = ($urandom_range(0, 3) == 0);
        foreach (name_buf[i]) send_byte(name_buf[i], burst);
        send_byte(hsc_pkg::CH_NUL, burst);
    endtask

    task automatic run_directed();
        string names[$];
        names = '{"", "a.b", "Example.COM", "A-Z.z9-0", "-ab.com", "ab-.com", "a..b",
                  "a.b.", "localhost", "192.168.0.1", "0.0.0.0", "255.255.255.255",
                  "256.1.1.1", "01.2.3.4", "1.2.3", "1.2.3.4.5", "example.123",
                  "123.example", "a_b.com"};
        foreach (names[i]) begin
            name_buf.delete();
            push_str(names[i]);
            send_name();
        end
        // bytes outside the name set: high bit set, all ones, control
        name_buf.delete();
        push_str("ab");
        name_buf.push_back(8'h80);
        name_buf.push_back(8'hFF);
        name_buf.push_back(8'h01);
        push_str(".com");
        send_name();
        // longest label, then one byte too long
        for (int len = MAX_LABEL_BYTES; len <= MAX_LABEL_BYTES + 1; len++) begin
            name_buf.delete();
            push_fixed_labels(1, len, "q");
            push_str(".com");
            send_name();
        end
        // longest name, one byte over, far over (count saturates)
        for (int k = 0; k < 3; k++) begin
            name_buf.delete();
            push_fixed_labels(3, MAX_LABEL_BYTES, "x");
            name_buf.push_back(hsc_pkg::CH_DOT);
            push_fixed_labels(1, (k == 2) ? 63 : 61 + k, "y");
            if (k == 2) begin
                name_buf.push_back(hsc_pkg::CH_DOT);
                push_fixed_labels(1, 40, "z");
            end
            send_name();
        end
        // most labels that fit, then one label more
        for (int n = MAX_LABELS; n <= MAX_LABELS + 1; n++) begin
            name_buf.delete();
            push_fixed_labels(n, 1, "a");
            send_name();
        end
    endtask

    initial begin
        wait (i_rst_n);
        forever begin
            int r;
            if (hold_now) begin
                hold_now = 0;
                // long hold-off: the block queue fills and input stalls
                i_out_stall <= 1'b1;
                repeat (250) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else if (r < 65) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(30, 80)) @(posedge i_clk);
                end else if (r < 92) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(5, 30)) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_verdict({o_verdict, o_usable, o_name_length, o_label_total,
                                 o_is_ipv4_literal, o_reason_code});
    end

    initial begin
        bit second_hold;
        second_hold = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        hold_now = 1;
        while (random_bytes < RANDOM_BYTES) begin
            build_random_name();
            random_bytes += name_buf.size() + 1;
            send_name();
            if (!second_hold && random_bytes > RANDOM_BYTES / 2) begin
                second_hold = 1;
                hold_now    = 1;
            end
        end
        i_in_valid <= 1'b0;
        while (board.pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== hostname_syntax_checker_core.f =====
sv/hsc_pkg.sv
sv/hsc_front.sv
sv/hsc_queue.sv
sv/hsc_back.sv
sv/hostname_syntax_checker_core.sv
test/tb.sv
